// File: rtl/ac_pkg.sv
// Package for the multi-pattern matcher: default sizes, item op codes,
// result status codes and the sequencer state type. No dependencies.
`default_nettype none
package ac_pkg;

    localparam int NODES_DEF       = 256;
    localparam int SYMBOL_BITS_DEF = 16;
    localparam int ID_BITS_DEF     = 8;

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_COMPILE = 2'd1,
        OP_SEARCH  = 2'd2,
        OP_RESTART = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_STALE = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SCAN_END,
        S_MARK_CHK,
        S_FAIL_WAIT,
        S_ADV_DONE,
        S_SRCH_WAIT,
        S_C1_RD,
        S_C1_CMP,
        S_CQ_RD,
        S_CQ_WAIT,
        S_CF_WAIT,
        S_C2_RD,
        S_C2_CMP,
        S_OUT
    } state_t;

endpackage
`default_nettype wire

// File: rtl/ac_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
`default_nettype none
module ac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: rtl/aho_corasick_matcher.sv
// Multi-pattern matcher top level: trie build, failure-link compile and search.
// Depends on ac_pkg and ac_ram.
//
// Every item gives one result. The trie lives in four RAMs (parent and
// symbol, failure link, match flag and id, walk queue), all with a registered
// read. A child lookup scans nodes 1 to node_count-1, reading and then
// comparing each node in turn; an add does one lookup, and a search does one
// for each node tried along the failure chain. A compile visits every node
// once per queued node with one lookup for each child. Results wait in an
// output register; the next item is taken after it is transferred.
`default_nettype none
module aho_corasick_matcher #(
    parameter int NODES       = ac_pkg::NODES_DEF,
    parameter int SYMBOL_BITS = ac_pkg::SYMBOL_BITS_DEF,
    parameter int ID_BITS     = ac_pkg::ID_BITS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [1:0]             s_op,
    input  wire logic [SYMBOL_BITS-1:0] s_symbol,
    input  wire logic                   s_pattern_end,
    input  wire logic [ID_BITS-1:0]     s_pattern_id,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [1:0]                  m_status,
    output logic                        m_matched,
    output logic [ID_BITS-1:0]          m_match_id
);
    import ac_pkg::*;

    localparam int IDX_W = $clog2(NODES);
    localparam int CNT_W = IDX_W + 1;
    localparam int PS_W  = IDX_W + SYMBOL_BITS;
    localparam int MT_W  = ID_BITS + 1;

    state_t                 state_reg, state_next;
    op_t                    op_reg, op_next;
    logic                   last_reg, last_next;
    logic [ID_BITS-1:0]     id_reg, id_next;
    logic [IDX_W-1:0]       cursor_reg, cursor_next;
    logic [IDX_W-1:0]       pos_reg, pos_next;
    logic [CNT_W-1:0]       nc_reg, nc_next;
    logic                   stale_reg, stale_next;
    logic [IDX_W-1:0]       st_reg, st_next;
    logic [SYMBOL_BITS-1:0] ssym_reg, ssym_next;
    logic [CNT_W-1:0]       sc_reg, sc_next;
    logic                   found_reg, found_next;
    logic [IDX_W-1:0]       fidx_reg, fidx_next;
    logic [IDX_W-1:0]       adv_reg, adv_next;
    logic [CNT_W-1:0]       cc_reg, cc_next;
    logic [IDX_W-1:0]       head_reg, head_next;
    logic [IDX_W-1:0]       tail_reg, tail_next;
    logic [IDX_W-1:0]       cur_reg, cur_next;
    logic [IDX_W-1:0]       curfail_reg, curfail_next;
    status_t                status_reg, status_next;
    logic                   matched_reg, matched_next;
    logic [ID_BITS-1:0]     mid_reg, mid_next;

    logic             ps_we, fl_we, mt_we, q_we;
    logic [IDX_W-1:0] ps_waddr, ps_raddr, fl_waddr, fl_raddr;
    logic [IDX_W-1:0] mt_waddr, mt_raddr, q_waddr, q_raddr;
    logic [PS_W-1:0]  ps_wdata, ps_rdata;
    logic [IDX_W-1:0] fl_wdata, fl_rdata, q_wdata, q_rdata;
    logic [MT_W-1:0]  mt_wdata, mt_rdata;

    ac_ram #(.WIDTH(PS_W), .DEPTH(NODES)) u_ps_ram (
        .aclk(aclk), .we(ps_we), .waddr(ps_waddr), .wdata(ps_wdata),
        .raddr(ps_raddr), .rdata(ps_rdata)
    );
    ac_ram #(.WIDTH(IDX_W), .DEPTH(NODES)) u_fail_ram (
        .aclk(aclk), .we(fl_we), .waddr(fl_waddr), .wdata(fl_wdata),
        .raddr(fl_raddr), .rdata(fl_rdata)
    );
    ac_ram #(.WIDTH(MT_W), .DEPTH(NODES)) u_match_ram (
        .aclk(aclk), .we(mt_we), .waddr(mt_waddr), .wdata(mt_wdata),
        .raddr(mt_raddr), .rdata(mt_rdata)
    );
    ac_ram #(.WIDTH(IDX_W), .DEPTH(NODES)) u_queue_ram (
        .aclk(aclk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            nc_reg     <= CNT_W'(1);
            cursor_reg <= '0;
            pos_reg    <= '0;
            stale_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            nc_reg     <= nc_next;
            cursor_reg <= cursor_next;
            pos_reg    <= pos_next;
            stale_reg  <= stale_next;
        end
        op_reg      <= op_next;
        last_reg    <= last_next;
        id_reg      <= id_next;
        st_reg      <= st_next;
        ssym_reg    <= ssym_next;
        sc_reg      <= sc_next;
        found_reg   <= found_next;
        fidx_reg    <= fidx_next;
        adv_reg     <= adv_next;
        cc_reg      <= cc_next;
        head_reg    <= head_next;
        tail_reg    <= tail_next;
        cur_reg     <= cur_next;
        curfail_reg <= curfail_next;
        status_reg  <= status_next;
        matched_reg <= matched_next;
        mid_reg     <= mid_next;
    end

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        last_next    = last_reg;
        id_next      = id_reg;
        cursor_next  = cursor_reg;
        pos_next     = pos_reg;
        nc_next      = nc_reg;
        stale_next   = stale_reg;
        st_next      = st_reg;
        ssym_next    = ssym_reg;
        sc_next      = sc_reg;
        found_next   = found_reg;
        fidx_next    = fidx_reg;
        adv_next     = adv_reg;
        cc_next      = cc_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        cur_next     = cur_reg;
        curfail_next = curfail_reg;
        status_next  = status_reg;
        matched_next = matched_reg;
        mid_next     = mid_reg;

        ps_we = 1'b0; ps_waddr = nc_reg[IDX_W-1:0];
        ps_wdata = {cursor_reg, ssym_reg}; ps_raddr = sc_reg[IDX_W-1:0];
        fl_we = 1'b0; fl_waddr = nc_reg[IDX_W-1:0]; fl_wdata = '0; fl_raddr = st_reg;
        mt_we = 1'b0; mt_waddr = nc_reg[IDX_W-1:0];
        mt_wdata = {last_reg, last_reg ? id_reg : ID_BITS'(0)}; mt_raddr = fidx_reg;
        q_we = 1'b0; q_waddr = tail_reg; q_wdata = cc_reg[IDX_W-1:0]; q_raddr = head_reg;

        s_ready = 1'b0;
        m_valid = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next      = op_t'(s_op);
                    last_next    = s_pattern_end;
                    id_next      = s_pattern_id;
                    ssym_next    = s_symbol;
                    sc_next      = CNT_W'(1);
                    status_next  = STATUS_OK;
                    matched_next = 1'b0;
                    mid_next     = '0;
                    unique case (op_t'(s_op))
                        OP_ADD: begin
                            stale_next = 1'b1;
                            st_next    = cursor_reg;
                            state_next = S_SCAN_RD;
                        end
                        OP_COMPILE: begin
                            cc_next    = CNT_W'(1);
                            head_next  = '0;
                            tail_next  = '0;
                            state_next = S_C1_RD;
                        end
                        OP_SEARCH: begin
                            if (stale_reg) begin
                                status_next = STATUS_STALE;
                                state_next  = S_OUT;
                            end else begin
                                st_next    = pos_reg;
                                state_next = S_SCAN_RD;
                            end
                        end
                        OP_RESTART: begin
                            pos_next   = '0;
                            state_next = S_OUT;
                        end
                        default: state_next = S_OUT;
                    endcase
                end
            end
            // child lookup: scan nodes for {parent, symbol}
            S_SCAN_RD: begin
                if (sc_reg >= nc_reg) begin
                    found_next = 1'b0;
                    state_next = S_SCAN_END;
                end else begin
                    state_next = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if (ps_rdata == {st_reg, ssym_reg}) begin
                    found_next = 1'b1;
                    fidx_next  = sc_reg[IDX_W-1:0];
                    state_next = S_SCAN_END;
                end else begin
                    sc_next    = sc_reg + CNT_W'(1);
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_END: begin
                if (op_reg == OP_ADD) begin
                    if (found_reg) begin
                        cursor_next = fidx_reg;
                        // fetch the match entry of the existing end node
                        state_next  = last_reg ? S_MARK_CHK : S_OUT;
                        if (last_reg) begin
                            cursor_next = '0;
                        end
                    end else if (nc_reg < CNT_W'(NODES)) begin
                        ps_we       = 1'b1;
                        fl_we       = 1'b1;
                        mt_we       = 1'b1;
                        nc_next     = nc_reg + CNT_W'(1);
                        cursor_next = last_reg ? IDX_W'(0) : nc_reg[IDX_W-1:0];
                        state_next  = S_OUT;
                    end else begin
                        status_next = STATUS_FULL;
                        if (last_reg) begin
                            cursor_next = '0;
                        end
                        state_next = S_OUT;
                    end
                end else begin
                    if (found_reg) begin
                        adv_next   = fidx_reg;
                        state_next = S_ADV_DONE;
                    end else if (st_reg == '0) begin
                        adv_next   = '0;
                        state_next = S_ADV_DONE;
                    end else begin
                        // read failure link of st_reg
                        state_next = S_FAIL_WAIT;
                    end
                end
            end
            S_MARK_CHK: begin
                if (!mt_rdata[MT_W-1]) begin
                    mt_we    = 1'b1;
                    mt_waddr = fidx_reg;
                    mt_wdata = {1'b1, id_reg};
                end
                state_next = S_OUT;
            end
            S_FAIL_WAIT: begin
                st_next    = fl_rdata;
                sc_next    = CNT_W'(1);
                state_next = S_SCAN_RD;
            end
            S_ADV_DONE: begin
                if (op_reg == OP_SEARCH) begin
                    pos_next   = adv_reg;
                    mt_raddr   = adv_reg;
                    state_next = S_SRCH_WAIT;
                end else begin
                    fl_we      = 1'b1;
                    fl_waddr   = cc_reg[IDX_W-1:0];
                    fl_wdata   = adv_reg;
                    cc_next    = cc_reg + CNT_W'(1);
                    state_next = S_C2_RD;
                end
            end
            S_SRCH_WAIT: begin
                // the root never ends a pattern and its entry is never written
                if (adv_reg != '0 && mt_rdata[MT_W-1]) begin
                    matched_next = 1'b1;
                    mid_next     = mt_rdata[ID_BITS-1:0];
                end else begin
                    matched_next = 1'b0;
                    mid_next     = '0;
                end
                state_next   = S_OUT;
            end
            // compile, first pass: queue the children of the root
            S_C1_RD: begin
                ps_raddr = cc_reg[IDX_W-1:0];
                state_next = (cc_reg >= nc_reg) ? S_CQ_RD : S_C1_CMP;
            end
            S_C1_CMP: begin
                if (ps_rdata[PS_W-1:SYMBOL_BITS] == '0) begin
                    fl_we     = 1'b1;
                    fl_waddr  = cc_reg[IDX_W-1:0];
                    fl_wdata  = '0;
                    q_we      = 1'b1;
                    tail_next = tail_reg + IDX_W'(1);
                end
                cc_next    = cc_reg + CNT_W'(1);
                state_next = S_C1_RD;
            end
            S_CQ_RD: begin
                if (head_reg >= tail_reg) begin
                    stale_next = 1'b0;
                    state_next = S_OUT;
                end else begin
                    head_next  = head_reg + IDX_W'(1);
                    state_next = S_CQ_WAIT;
                end
            end
            S_CQ_WAIT: begin
                cur_next   = q_rdata;
                fl_raddr   = q_rdata;
                state_next = S_CF_WAIT;
            end
            S_CF_WAIT: begin
                curfail_next = fl_rdata;
                cc_next      = CNT_W'(1);
                state_next   = S_C2_RD;
            end
            S_C2_RD: begin
                ps_raddr = cc_reg[IDX_W-1:0];
                state_next = (cc_reg >= nc_reg) ? S_CQ_RD : S_C2_CMP;
            end
            S_C2_CMP: begin
                if (ps_rdata[PS_W-1:SYMBOL_BITS] == cur_reg) begin
                    q_we       = 1'b1;
                    tail_next  = tail_reg + IDX_W'(1);
                    st_next    = curfail_reg;
                    ssym_next  = ps_rdata[SYMBOL_BITS-1:0];
                    sc_next    = CNT_W'(1);
                    state_next = S_SCAN_RD;
                end else begin
                    cc_next    = cc_reg + CNT_W'(1);
                    state_next = S_C2_RD;
                end
            end
            S_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign m_status   = status_reg;
    assign m_matched  = matched_reg;
    assign m_match_id = mid_reg;

endmodule
`default_nettype wire
